FILE: hdl/bsp_pkg.sv
// Shared types and constants for the shortest-path relax engine.
`timescale 1ns / 1ps

package bsp_pkg;

	localparam int NODE_W   = 10;
	localparam int DIST_W   = 31;
	localparam int WEIGHT_W = 24;
	localparam int CMD_W    = 2;

	localparam int NODES_DEF = 1024;

	localparam logic [DIST_W-1:0] DIST_INF = 31'd536870911;
	localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

	localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELAX  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

	typedef enum logic [0:0] {
		ALU_ADD_SAT,
		ALU_MIN
	} alu_op_t;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [NODE_W-1:0]   from_node;
		logic [NODE_W-1:0]   dst_node;
		logic [WEIGHT_W-1:0] weight;
	} in_word_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [DIST_W-1:0] distance;
		logic              improved;
		logic              changed_any;
	} out_word_t;

	typedef struct packed {
		logic [DIST_W-1:0] res;
		logic              lt;
	} alu_out_t;

endpackage

FILE: hdl/bsp_shortest_path_relax.sv
// Top level of the double-banked shortest-path relax engine.
`timescale 1ns / 1ps

// One command word is taken at a time; in_stall stays high until its result
// word has been loaded into the output register. Init and commit sweep
// every entry of both distance banks through their single read and write
// ports, one entry a cycle, and relax chains a bank read, a saturating add
// and a compare through the one shared distance unit. A result may wait in
// the output register while the next command is accepted. Distances are
// undefined until the first init.
module bsp_shortest_path_relax #(
	parameter int NODES = bsp_pkg::NODES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  bsp_pkg::in_word_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output bsp_pkg::out_word_t        out_data,
	input  logic                      cfg_we,
	input  logic [bsp_pkg::NODE_W-1:0] cfg_data
);
	import bsp_pkg::*;

	localparam int NODE_SPAN = 1 << NODE_W;
	localparam int DEPTH     = (NODES < NODE_SPAN) ? NODES : NODE_SPAN;
	localparam int AW        = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_RRD,
		S_RADD,
		S_RCMP,
		S_CSWP,
		S_CDRN,
		S_RDI,
		S_RDD,
		S_DONE
	} state_t;

	state_t            state_q;
	in_word_t          item_q;
	out_word_t         res_q;
	out_word_t         out_q;
	logic              out_valid_q;
	logic              version_q;
	logic              changed_q;
	logic [NODE_W-1:0] source_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     addr_s1;
	logic              rd_vld_s1;
	logic [DIST_W-1:0] cand_q;

	logic              src_in;
	logic              dst_in;
	logic              srcn_in;
	logic [AW-1:0]     src_a;
	logic [AW-1:0]     dst_a;
	logic [DIST_W-1:0] rd0;
	logic [DIST_W-1:0] rd1;
	logic [DIST_W-1:0] cur_rd;
	logic [DIST_W-1:0] nxt_rd;
	logic              improve;

	alu_op_t           alu_op;
	logic [DIST_W-1:0] alu_a;
	logic [DIST_W-1:0] alu_b;
	alu_out_t          alu_out;

	logic              we0;
	logic              we1;
	logic [AW-1:0]     waddr;
	logic [DIST_W-1:0] wdata0;
	logic [DIST_W-1:0] wdata1;
	logic [AW-1:0]     raddr0;
	logic [AW-1:0]     raddr1;

	assign src_in  = (32'(item_q.from_node) < NODES);
	assign dst_in  = (32'(item_q.dst_node) < NODES);
	assign srcn_in = (32'(source_q) < NODES);
	assign src_a   = item_q.from_node[AW-1:0];
	assign dst_a   = item_q.dst_node[AW-1:0];
	assign cur_rd  = version_q ? rd1 : rd0;
	assign nxt_rd  = version_q ? rd0 : rd1;
	assign improve = alu_out.lt && dst_in;

	bsp_alu u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.result (alu_out)
	);

	bsp_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr),
		.wdata (wdata0),
		.raddr (raddr0),
		.rdata (rd0)
	);

	bsp_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr),
		.wdata (wdata1),
		.raddr (raddr1),
		.rdata (rd1)
	);

	always_comb begin
		alu_op = ALU_MIN;
		alu_a  = rd0;
		alu_b  = rd1;
		case (state_q)
			S_RADD: begin
				alu_op = ALU_ADD_SAT;
				alu_a  = src_in ? cur_rd : DIST_INF;
				alu_b  = DIST_W'(item_q.weight);
			end
			S_RCMP: begin
				alu_a = cand_q;
				alu_b = nxt_rd;
			end
			default: begin
				alu_op = ALU_MIN;
			end
		endcase
	end

	always_comb begin
		we0    = 1'b0;
		we1    = 1'b0;
		waddr  = addr_s1;
		wdata0 = alu_out.res;
		wdata1 = alu_out.res;
		raddr0 = idx_q;
		raddr1 = idx_q;
		case (state_q)
			S_INIT: begin
				we0    = 1'b1;
				we1    = 1'b1;
				waddr  = idx_q;
				wdata0 = (srcn_in && idx_q == source_q[AW-1:0]) ? '0 : DIST_INF;
				wdata1 = DIST_INF;
			end
			S_RRD, S_RADD: begin
				raddr0 = version_q ? dst_a : src_a;
				raddr1 = version_q ? src_a : dst_a;
			end
			S_RCMP: begin
				we0    = version_q && improve;
				we1    = !version_q && improve;
				waddr  = dst_a;
				wdata0 = cand_q;
				wdata1 = cand_q;
			end
			S_CSWP: begin
				we0 = rd_vld_s1;
				we1 = rd_vld_s1;
			end
			S_CDRN: begin
				we0 = 1'b1;
				we1 = 1'b1;
			end
			S_RDI: begin
				raddr0 = src_a;
				raddr1 = src_a;
			end
			default: begin
				we0 = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			version_q   <= 1'b0;
			changed_q   <= 1'b0;
			source_q    <= '0;
			idx_q       <= '0;
			addr_s1     <= '0;
			rd_vld_s1   <= 1'b0;
			cand_q      <= '0;
		end else begin
			if (cfg_we) begin
				source_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					idx_q     <= '0;
					if (in_valid) begin
						item_q <= in_data;
						case (in_data.cmd)
							CMD_INIT:   state_q <= S_INIT;
							CMD_RELAX:  state_q <= S_RRD;
							CMD_COMMIT: state_q <= S_CSWP;
							CMD_READ:   state_q <= S_RDI;
							default:    state_q <= S_IDLE;
						endcase
					end
				end
				S_INIT: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == LAST) begin
						version_q            <= 1'b0;
						res_q.node           <= source_q;
						res_q.distance       <= srcn_in ? '0 : DIST_INF;
						res_q.improved       <= srcn_in;
						res_q.changed_any    <= 1'b0;
						state_q              <= S_DONE;
					end
				end
				S_RRD: begin
					state_q <= S_RADD;
				end
				S_RADD: begin
					cand_q  <= alu_out.res;
					state_q <= S_RCMP;
				end
				S_RCMP: begin
					if (improve) begin
						changed_q <= 1'b1;
					end
					res_q.node        <= item_q.dst_node;
					res_q.distance    <= cand_q;
					res_q.improved    <= improve;
					res_q.changed_any <= 1'b0;
					state_q           <= S_DONE;
				end
				S_CSWP: begin
					rd_vld_s1 <= 1'b1;
					addr_s1   <= idx_q;
					idx_q     <= idx_q + AW'(1);
					if (idx_q == LAST) begin
						state_q <= S_CDRN;
					end
				end
				S_CDRN: begin
					version_q         <= !version_q;
					changed_q         <= 1'b0;
					res_q.node        <= '0;
					res_q.distance    <= '0;
					res_q.improved    <= 1'b0;
					res_q.changed_any <= changed_q;
					state_q           <= S_DONE;
				end
				S_RDI: begin
					state_q <= S_RDD;
				end
				S_RDD: begin
					res_q.node        <= item_q.from_node;
					res_q.distance    <= src_in ? cur_rd : DIST_INF;
					res_q.improved    <= 1'b0;
					res_q.changed_any <= 1'b0;
					state_q           <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("word accepted but engine not busy");

	a_changed_only_relax: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(changed_q) |-> ($past(state_q) == S_RCMP))
		else $error("round change flag set outside relax compare");

	a_version_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(version_q != $past(version_q)) |->
		($past(state_q) == S_CDRN || $past(state_q) == S_INIT))
		else $error("bank version changed outside commit or init");

endmodule

FILE: hdl/bsp_alu.sv
// Shared distance unit: saturating add, minimum and less-than compare.
`timescale 1ns / 1ps

module bsp_alu (
	input  bsp_pkg::alu_op_t          op,
	input  logic [bsp_pkg::DIST_W-1:0] a,
	input  logic [bsp_pkg::DIST_W-1:0] b,
	output bsp_pkg::alu_out_t         result
);
	import bsp_pkg::*;

	logic [DIST_W:0] sum;
	logic            lt;

	assign sum = {1'b0, a} + {1'b0, b};
	assign lt  = (a < b);

	always_comb begin
		result.lt = lt;
		case (op)
			ALU_ADD_SAT: begin
				result.res = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
			end
			ALU_MIN: begin
				result.res = lt ? a : b;
			end
			default: begin
				result.res = b;
			end
		endcase
	end

endmodule

FILE: hdl/bsp_bank.sv
// One bank of node distances: one write port, one registered read port.
`timescale 1ns / 1ps

module bsp_bank #(
	parameter int DEPTH = bsp_pkg::NODES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [bsp_pkg::DIST_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [bsp_pkg::DIST_W-1:0] rdata
);
	import bsp_pkg::*;

	logic [DIST_W-1:0] mem_q [DEPTH];
	logic [DIST_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: verif/tb_top.sv
// Testbench for the double-banked shortest-path relax engine.
`timescale 1ns / 1ps

module tb_top;
	import bsp_pkg::*;

	localparam int CYCLE_LIMIT   = 5000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 1930;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_word_t          in_data  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_word_t         out_data;
	logic              cfg_we   = 1'b0;
	logic [NODE_W-1:0] cfg_data = '0;

	logic [DIST_W-1:0] dist_bank [2][NODES_DEF];
	logic              cur_version = 1'b0;
	logic              round_dirty = 1'b0;
	logic [NODE_W-1:0] start_node  = '0;
	out_word_t         pending_results[$];

	bit          failed       = 1'b0;
	bit          pacing_on    = 1'b1;
	bit          stall_enable = 1'b1;
	int unsigned burst_left   = 0;
	int unsigned stall_left   = 0;
	int unsigned cycle_count  = 0;

	always #2 clk = ~clk;

	bsp_shortest_path_relax u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	task automatic relax_engine_model(input in_word_t w, output out_word_t r);
		logic [31:0]       sum;
		logic [DIST_W-1:0] cand;
		logic [DIST_W-1:0] lowest;
		r = '0;
		case (w.cmd)
		CMD_INIT: begin
			for (int i = 0; i < NODES_DEF; i++) begin
				dist_bank[0][i] = DIST_INF;
				dist_bank[1][i] = DIST_INF;
			end
			cur_version = 1'b0;
			dist_bank[0][start_node] = '0;
			r.node = start_node;
			r.improved = 1'b1;
		end
		CMD_RELAX: begin
			sum = {1'b0, dist_bank[cur_version][w.from_node]} + {8'd0, w.weight};
			cand = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
			if (cand < dist_bank[!cur_version][w.dst_node]) begin
				dist_bank[!cur_version][w.dst_node] = cand;
				r.improved = 1'b1;
				round_dirty = 1'b1;
			end
			r.node = w.dst_node;
			r.distance = cand;
		end
		CMD_COMMIT: begin
			for (int i = 0; i < NODES_DEF; i++) begin
				lowest = (dist_bank[0][i] < dist_bank[1][i]) ? dist_bank[0][i] : dist_bank[1][i];
				dist_bank[0][i] = lowest;
				dist_bank[1][i] = lowest;
			end
			cur_version = !cur_version;
			r.changed_any = round_dirty;
			round_dirty = 1'b0;
		end
		default: begin
			r.node = w.from_node;
			r.distance = dist_bank[cur_version][w.from_node];
		end
		endcase
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (cfg_we) begin
				start_node = cfg_data;
			end
			if (in_valid && !in_stall) begin
				relax_engine_model(in_data, want);
				pending_results.insert(pending_results.size(), want);
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result word with none pending: %h", $time, out_data);
					failed = 1'b1;
				end else begin
					want = pending_results.pop_front();
					if (out_data.node !== want.node) begin
						$display("%0t: node expected %0d got %0d", $time, want.node,
							out_data.node);
						failed = 1'b1;
					end
					if (out_data.distance !== want.distance) begin
						$display("%0t: distance expected %0d got %0d", $time, want.distance,
							out_data.distance);
						failed = 1'b1;
					end
					if (out_data.improved !== want.improved) begin
						$display("%0t: improved expected %0b got %0b", $time, want.improved,
							out_data.improved);
						failed = 1'b1;
					end
					if (out_data.changed_any !== want.changed_any) begin
						$display("%0t: changed_any expected %0b got %0b", $time,
							want.changed_any, out_data.changed_any);
						failed = 1'b1;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (out_stall || !stall_enable) begin
			out_stall <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 5);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bsp_shortest_path_relax test failed");
			$finish;
		end
	end

	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] src,
		input logic [NODE_W-1:0] dst, input logic [WEIGHT_W-1:0] wgt);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = pacing_on ? $urandom_range(0, 6) : 0;
			burst_left = $urandom_range(1, 16);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= '{cmd: cmd, from_node: src, dst_node: dst, weight: wgt};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_source(input logic [NODE_W-1:0] n);
		drain_results();
		cfg_we <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed_edges();
		set_source('1);
		send_word(CMD_INIT, '0, '0, '0);
		send_word(CMD_READ, '1, '0, '0);
		send_word(CMD_READ, '0, '0, '0);
		send_word(CMD_RELAX, '1, '0, '1);
		send_word(CMD_RELAX, '1, '0, '0);
		send_word(CMD_RELAX, '1, '0, '0);
		send_word(CMD_READ, '0, '0, '0);
		send_word(CMD_COMMIT, '0, '0, '0);
		send_word(CMD_READ, '0, '0, '0);
		send_word(CMD_COMMIT, '0, '0, '0);
		send_word(CMD_RELAX, '0, '1, 24'd5);
		send_word(CMD_RELAX, 10'd5, 10'd6, '1);
		send_word(CMD_COMMIT, '0, '0, '0);
		send_word(CMD_READ, 10'd6, '0, '0);
	endtask

	task automatic test_init_keeps_flag();
		set_source('0);
		send_word(CMD_RELAX, '1, 10'd512, 24'h555555);
		send_word(CMD_INIT, '0, '0, '0);
		send_word(CMD_COMMIT, '0, '0, '0);
		send_word(CMD_READ, '0, '0, '0);
		send_word(CMD_RELAX, '0, '0, '0);
		send_word(CMD_RELAX, '0, 10'd1, 24'hAAAAAA);
		send_word(CMD_READ, 10'd1, '0, '0);
	endtask

	task automatic test_random_rounds();
		int unsigned       sent;
		int unsigned       rounds;
		int unsigned       round_len;
		int unsigned       span;
		int unsigned       pick;
		logic [NODE_W-1:0] base;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
		logic [WEIGHT_W-1:0] wgt;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 4))
			0: base = '0;
			1: base = '1;
			default: base = NODE_W'($urandom_range(0, NODES_DEF - 1));
			endcase
			set_source(base);
			pacing_on = ($urandom_range(0, 3) != 0);
			stall_enable = pacing_on;
			span = $urandom_range(4, 40);
			send_word(CMD_INIT, '0, '0, '0);
			sent++;
			rounds = $urandom_range(3, 10);
			for (int r = 0; r < rounds && sent < RANDOM_ITEMS; r++) begin
				round_len = $urandom_range(4, 30);
				for (int k = 0; k < round_len; k++) begin
					pick = $urandom_range(0, 99);
					src = NODE_W'(base + $urandom_range(0, span - 1));
					dst = NODE_W'(base + $urandom_range(0, span - 1));
					wgt = ($urandom_range(0, 4) != 0) ? WEIGHT_W'($urandom_range(0, 255))
						: WEIGHT_W'($urandom);
					if (pick < 70) begin
						send_word(CMD_RELAX, src, dst, wgt);
					end else if (pick < 85) begin
						send_word(CMD_READ, src, NODE_W'($urandom), WEIGHT_W'($urandom));
					end else if (pick < 95) begin
						send_word(CMD_RELAX, NODE_W'($urandom), NODE_W'($urandom),
							WEIGHT_W'($urandom));
					end else if (pick < 99) begin
						send_word(CMD_READ, NODE_W'($urandom), NODE_W'($urandom),
							WEIGHT_W'($urandom));
					end else begin
						send_word(CMD_INIT, NODE_W'($urandom), NODE_W'($urandom),
							WEIGHT_W'($urandom));
					end
					sent++;
				end
				send_word(CMD_COMMIT, NODE_W'($urandom), NODE_W'($urandom),
					WEIGHT_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_init_keeps_flag();
		test_random_rounds();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (!failed) begin
			$display("bsp_shortest_path_relax test passed");
		end else begin
			$display("bsp_shortest_path_relax test failed");
		end
		$finish;
	end

endmodule
